[rtl/assert_macros.svh]
// Assertion macros used by the checker file tmtw_chk.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tmtw_pkg.sv]
// Package for the text-mode terminal writer: request codes, controller states,
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmtw_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_ATTR = 1'b0;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_PUT,
        ST_TAB,
        ST_NEWROW,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLANK,
        ST_RD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_CLR,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ZERO,
        WR_BLANK,
        WR_CHAR,
        WR_SPACE,
        WR_MOVE
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_CELL,
        RD_MOVE
    } rd_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_COL0,
        CUR_ADV,
        CUR_NEWROW
    } cur_op_t;

    typedef struct packed {
        logic    load_req;
        ptr_op_t ptr_op;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        cur_op_t cur_op;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        req_t req;
        logic is_newline;
        logic is_return;
        logic is_tab;
        logic col_last;
        logic row_last;
        logic tab_stop;
        logic ptr_last_move;
        logic ptr_last_cell;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/tmtw_ctrl.sv]
// Controller state machine of the terminal writer: sequences put, tab, scroll,
// clear, read and the power-up clearing pass. Depends on tmtw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmtw_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire tmtw_pkg::dp_status_t  status,
    output tmtw_pkg::ctrl_cmd_t        cmd
);
    import tmtw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (status.ptr_last_cell) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (status.req)
                    REQ_PUT: begin
                        if (status.is_newline)     state_next = ST_NEWROW;
                        else if (status.is_return) state_next = ST_DONE;
                        else if (status.is_tab)    state_next = ST_TAB;
                        else                       state_next = ST_PUT;
                    end
                    REQ_CLEAR: state_next = ST_BLANK;
                    REQ_READ:  state_next = ST_RD;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_PUT: begin
                state_next = status.col_last ? ST_NEWROW : ST_DONE;
            end
            ST_TAB: begin
                if (status.col_last)      state_next = ST_NEWROW;
                else if (status.tab_stop) state_next = ST_DONE;
            end
            ST_NEWROW: begin
                state_next = status.row_last ? ST_SCR_RD : ST_DONE;
            end
            ST_SCR_RD: state_next = ST_SCR_WR;
            ST_SCR_WR: begin
                state_next = status.ptr_last_move ? ST_BLANK : ST_SCR_RD;
            end
            ST_BLANK: begin
                if (status.ptr_last_cell) state_next = ST_DONE;
            end
            ST_RD: state_next = ST_DONE;
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.load_req = 1'b0;
        cmd.ptr_op   = PTR_HOLD;
        cmd.wr_sel   = WR_NONE;
        cmd.rd_sel   = RD_NONE;
        cmd.cur_op   = CUR_HOLD;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.wr_sel = WR_ZERO;
                cmd.ptr_op = PTR_INC;
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            ST_DECODE: begin
                case (status.req)
                    REQ_PUT: begin
                        if (!status.is_newline && status.is_return) cmd.cur_op = CUR_COL0;
                    end
                    REQ_CLEAR: begin
                        cmd.ptr_op = PTR_CLR;
                        cmd.cur_op = CUR_HOME;
                    end
                    default: ;
                endcase
            end
            ST_PUT: begin
                cmd.wr_sel = WR_CHAR;
                if (!status.col_last) cmd.cur_op = CUR_ADV;
            end
            ST_TAB: begin
                cmd.wr_sel = WR_SPACE;
                if (!status.col_last) cmd.cur_op = CUR_ADV;
            end
            ST_NEWROW: begin
                cmd.cur_op = CUR_NEWROW;
                if (status.row_last) cmd.ptr_op = PTR_CLR;
            end
            ST_SCR_RD: cmd.rd_sel = RD_MOVE;
            ST_SCR_WR: begin
                cmd.wr_sel = WR_MOVE;
                cmd.ptr_op = PTR_INC;
            end
            ST_BLANK: begin
                cmd.wr_sel = WR_BLANK;
                cmd.ptr_op = PTR_INC;
            end
            ST_RD: cmd.rd_sel = RD_CELL;
            ST_DONE: cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[rtl/tmtw_dp.sv]
// Datapath of the terminal writer: request latch, cursor, sweep pointer,
// cell store and result register. Depends on tmtw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmtw_dp #(
    parameter int ROWS = tmtw_pkg::ROWS_DEF,
    parameter int COLS = tmtw_pkg::COLS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tmtw_pkg::ctrl_cmd_t   cmd,
    output tmtw_pkg::dp_status_t       status,
    input  wire logic [7:0]            attr,
    input  wire logic [1:0]            s_req_type,
    input  wire logic [7:0]            s_char_code,
    input  wire logic [10:0]           s_cell_index,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [15:0]                m_read_cell,
    output logic [4:0]                 m_cursor_row_out,
    output logic [6:0]                 m_cursor_col_out
);
    import tmtw_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);

    req_t              req_reg;
    logic [7:0]        char_reg;
    logic [10:0]       idx_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic              out_valid_reg;
    logic [15:0]       out_cell_reg;
    logic [4:0]        out_row_reg;
    logic [6:0]        out_col_reg;

    logic [15:0]       mem [CELLS];
    logic [15:0]       rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic              idx_ok;

    assign cur_addr = ADDR_W'(row_reg * COLS) + ADDR_W'(col_reg);
    assign idx_ok   = 32'(idx_reg) < 32'(CELLS);

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg  <= req_t'(s_req_type);
            char_reg <= s_char_code;
            idx_reg  <= s_cell_index;
        end
    end

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        case (cmd.cur_op)
            CUR_HOME: begin
                row_next = '0;
                col_next = '0;
            end
            CUR_COL0: col_next = '0;
            CUR_ADV:  col_next = col_reg + 1'b1;
            CUR_NEWROW: begin
                col_next = '0;
                if (!status.row_last) row_next = row_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        ptr_next = ptr_reg;
        case (cmd.ptr_op)
            PTR_CLR: ptr_next = '0;
            PTR_INC: ptr_next = ptr_reg + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            ptr_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            ptr_reg <= ptr_next;
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = ptr_reg;
        wr_data = '0;
        case (cmd.wr_sel)
            WR_ZERO:  wr_data = '0;
            WR_BLANK: wr_data = {attr, CH_SPACE};
            WR_MOVE:  wr_data = rd_data_reg;
            WR_CHAR: begin
                wr_addr = cur_addr;
                wr_data = {attr, char_reg};
            end
            WR_SPACE: begin
                wr_addr = cur_addr;
                wr_data = {attr, CH_SPACE};
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg + ADDR_W'(COLS);
        case (cmd.rd_sel)
            RD_MOVE: rd_en = 1'b1;
            RD_CELL: begin
                rd_en   = idx_ok;
                rd_addr = ADDR_W'(idx_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_cell_reg <= (req_reg == REQ_READ && idx_ok) ? rd_data_reg : 16'h0000;
            out_row_reg  <= 5'(row_reg);
            out_col_reg  <= 7'(col_reg);
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_read_cell      = out_cell_reg;
    assign m_cursor_row_out = out_row_reg;
    assign m_cursor_col_out = out_col_reg;

    assign status.req           = req_reg;
    assign status.is_newline    = char_reg == CH_NEWLINE;
    assign status.is_return     = char_reg == CH_RETURN;
    assign status.is_tab        = char_reg == CH_TAB;
    assign status.col_last      = col_reg == COL_W'(COLS - 1);
    assign status.row_last      = row_reg == ROW_W'(ROWS - 1);
    assign status.tab_stop      = col_reg[1:0] == 2'b11;
    assign status.ptr_last_move = ptr_reg == ADDR_W'(CELLS - COLS - 1);
    assign status.ptr_last_cell = ptr_reg == ADDR_W'(CELLS - 1);
    assign status.out_free      = !out_valid_reg || m_ready;

endmodule

`default_nettype wire

[rtl/text_mode_terminal_writer_unit.sv]
// After accept: byte decode, put, done; newline decode, new row, done; read decode, read,
// done; carriage return decode, done. Words are taken only in idle, the next as the result
// appears. A tab writes spaces to the next tab stop or row end. A scroll copies rows up, a
// read and a write per cell through the single-write, single-read cell store, then blanks
// the last row; clear blanks all cells. Reset: synchronous, active low; a clearing pass then
// zeroes the store one cell per cycle, s_ready low; attribute writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_terminal_writer_unit #(
    parameter int ROWS = tmtw_pkg::ROWS_DEF,
    parameter int COLS = tmtw_pkg::COLS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tmtw_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tmtw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tmtw_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_req_type,
    input  wire logic [7:0]                    s_char_code,
    input  wire logic [10:0]                   s_cell_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [15:0]                        m_read_cell,
    output logic [4:0]                         m_cursor_row_out,
    output logic [6:0]                         m_cursor_col_out
);
    import tmtw_pkg::*;

    logic [7:0] attr_reg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_IDX_ATTR) begin
            attr_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_ATTR) ? PDATA_W'(attr_reg) : '0;

    tmtw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tmtw_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .attr             (attr_reg),
        .s_req_type       (s_req_type),
        .s_char_code      (s_char_code),
        .s_cell_index     (s_cell_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_cell      (m_read_cell),
        .m_cursor_row_out (m_cursor_row_out),
        .m_cursor_col_out (m_cursor_col_out)
    );

endmodule

`default_nettype wire

[rtl/tmtw_chk.sv]
// Port-level checker for the terminal writer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tmtw_chk #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_read_cell,
    input wire logic [4:0]  m_cursor_row_out,
    input wire logic [6:0]  m_cursor_col_out
);

    `ASSERT_ALWAYS(a_busy_after_reset, aclk, !aresetn |=> !s_ready, "ready during clear pass")

    `ASSERT_RST(a_one_word_at_a_time, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second word taken while busy")

    `ASSERT_RST(a_cursor_in_range, aclk, aresetn, m_valid |-> (m_cursor_col_out < COLS) && (m_cursor_row_out < ROWS), "cursor out of range")

    `ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_read_cell) && $stable(m_cursor_row_out) && $stable(m_cursor_col_out), "result word changed while stalled")

endmodule

bind text_mode_terminal_writer_unit tmtw_chk #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tmtw_chk (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_read_cell      (m_read_cell),
    .m_cursor_row_out (m_cursor_row_out),
    .m_cursor_col_out (m_cursor_col_out)
);

`default_nettype wire

[test/text_mode_terminal_writer_unit_tb.sv]
// Self-checking testbench for text_mode_terminal_writer_unit: random and directed terminal
// requests against an in-bench screen/cursor predictor, APB attribute writes between phases.
// Depends on tmtw_pkg and the text_mode_terminal_writer_unit RTL.
`timescale 1ns / 1ps

module text_mode_terminal_writer_unit_tb;
    import tmtw_pkg::*;

    localparam int unsigned ROWS = ROWS_DEF;
    localparam int unsigned COLS = COLS_DEF;
    localparam int unsigned CELLS = ROWS * COLS;
    localparam int unsigned TAB_STEP = 4;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_PRINTS = 50;
    localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * REG_IDX_ATTR);
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

    typedef struct packed {
        req_t        req;
        logic [7:0]  ch;
        logic [10:0] idx;
    } term_req_t;

    typedef struct packed {
        logic [15:0] rd_word;
        logic [4:0]  row;
        logic [6:0]  col;
    } term_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_req_type = '0;
    logic [7:0]          s_char_code = '0;
    logic [10:0]         s_cell_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [15:0]         m_read_cell;
    logic [4:0]          m_cursor_row_out;
    logic [6:0]          m_cursor_col_out;

    text_mode_terminal_writer_unit uut (.*);

    always #2 aclk = ~aclk;

    // predictor state
    logic [15:0]  screen_copy [CELLS];
    int unsigned  cur_row;
    int unsigned  cur_col;
    logic [7:0]   text_attr;

    term_req_t    request_queue [$];
    term_result_t expected_words [$];
    int unsigned  src_idle_pct = 0;
    int unsigned  snk_stall_pct = 0;
    int unsigned  words_sent = 0;
    bit           drain_hold = 1'b0;
    int unsigned  errors = 0;

    function automatic logic [15:0] mk_cell(logic [7:0] ch);
        return {text_attr, ch};
    endfunction

    function automatic void line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++)
                screen_copy[i] = screen_copy[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen_copy[i] = mk_cell(CH_SPACE);
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic bit store_glyph(logic [7:0] ch);
        screen_copy[cur_row * COLS + cur_col] = mk_cell(ch);
        cur_col++;
        if (cur_col >= COLS) begin
            line_feed();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic term_result_t apply_request(req_t req, logic [7:0] ch,
                                                   logic [10:0] idx);
        term_result_t res;
        int unsigned  stop;
        res = '0;
        case (req)
            REQ_PUT: begin
                if (ch == CH_NEWLINE) begin
                    line_feed();
                end else if (ch == CH_RETURN) begin
                    cur_col = 0;
                end else if (ch == CH_TAB) begin
                    // a wrap ends the tab early
                    stop = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
                    while (cur_col < stop) begin
                        if (store_glyph(CH_SPACE))
                            break;
                    end
                end else begin
                    void'(store_glyph(ch));
                end
            end
            REQ_CLEAR: begin
                foreach (screen_copy[i])
                    screen_copy[i] = mk_cell(CH_SPACE);
                cur_row = 0;
                cur_col = 0;
            end
            REQ_READ: begin
                if (idx < CELLS)
                    res.rd_word = screen_copy[idx];
            end
            default: ;
        endcase
        res.row = 5'(cur_row);
        res.col = 7'(cur_col);
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (errors < MAX_PRINTS)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic push_req(req_t req, logic [7:0] ch, logic [10:0] idx);
        request_queue.push_back('{req: req, ch: ch, idx: idx});
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [7:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {24'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ATTR_ADDR)
            text_attr = value;
    endtask

    task automatic apb_check_attr();
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ATTR_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[7:0] !== text_attr)
            report_mismatch("attribute readback", prdata[7:0], text_attr);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (request_queue.size() != 0 || s_valid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_random(int unsigned n);
        int unsigned added;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  ch;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(999);
            if (pick < 520)
                len = $urandom_range(1, 12);
            else if (pick >= 985)
                len = $urandom_range(40, 90);
            else if (pick >= 840 && pick < 850)
                len = $urandom_range(20, 30);
            else
                len = 1;
            for (int k = 0; k < len; k++) begin
                if (pick < 520 || pick >= 985) begin
                    ch = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
                    push_req(REQ_PUT, ch, 11'($urandom));
                end else if (pick < 620) begin
                    push_req(REQ_PUT, CH_TAB, 11'($urandom));
                end else if (pick < 700) begin
                    push_req(REQ_READ, 8'($urandom), 11'($urandom_range(0, 2047)));
                end else if (pick < 760) begin
                    push_req(REQ_READ, 8'($urandom), 11'($urandom_range(CELLS - COLS, CELLS - 1)));
                end else if (pick < 810 || (pick >= 840 && pick < 850)) begin
                    push_req(REQ_PUT, CH_NEWLINE, 11'($urandom));
                end else if (pick < 840) begin
                    push_req(REQ_PUT, CH_RETURN, 11'($urandom));
                end else if (pick < 865) begin
                    push_req(REQ_CLEAR, 8'($urandom), 11'($urandom));
                end else if (pick < 875) begin
                    push_req(REQ_NONE, 8'($urandom), 11'($urandom));
                end else begin
                    push_req(REQ_READ, 8'($urandom), 11'($urandom_range(0, 2 * COLS - 1)));
                end
            end
            added += len;
        end
    endtask

    always @(posedge aclk) begin : driver
        term_req_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_words.push_back(apply_request(req_t'(s_req_type), s_char_code,
                                                       s_cell_index));
            if (!s_valid || s_ready) begin
                if (drain_hold && expected_words.size() == 0)
                    drain_hold = 1'b0;
                if (request_queue.size() != 0 && !drain_hold &&
                        $urandom_range(99) >= src_idle_pct) begin
                    item = request_queue.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= item.req;
                    s_char_code <= item.ch;
                    s_cell_index <= item.idx;
                    words_sent++;
                    // hold off until the block has answered everything
                    if (words_sent % 400 == 200 || $urandom_range(199) == 0)
                        drain_hold = 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        term_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", m_read_cell, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_read_cell !== want.rd_word)
                        report_mismatch("read_cell", m_read_cell, want.rd_word);
                    if (m_cursor_row_out !== want.row)
                        report_mismatch("cursor_row_out", m_cursor_row_out, want.row);
                    if (m_cursor_col_out !== want.col)
                        report_mismatch("cursor_col_out", m_cursor_col_out, want.col);
                end
            end
        end
    end

    initial begin
        #100ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        foreach (screen_copy[i])
            screen_copy[i] = '0;
        cur_row = 0;
        cur_col = 0;
        text_attr = ATTR_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // unmapped register must be ignored; reset attribute reads back
        apb_write(SPARE_ADDR, 8'h5A);
        apb_check_attr();
        apb_write(ATTR_ADDR, 8'hFF);
        apb_check_attr();

        push_req(REQ_READ, 8'h00, 11'd0);
        push_req(REQ_READ, 8'hFF, 11'(CELLS - 1));
        push_req(REQ_READ, 8'h00, 11'(CELLS));
        push_req(REQ_READ, 8'h00, 11'h7FF);
        push_req(REQ_PUT, 8'h41, 11'h7FF);
        push_req(REQ_PUT, 8'h00, 11'h000);
        push_req(REQ_PUT, 8'hFF, 11'h000);
        push_req(REQ_PUT, CH_TAB, 11'h000);
        push_req(REQ_PUT, CH_TAB, 11'h000);
        push_req(REQ_READ, 8'h00, 11'd0);
        push_req(REQ_READ, 8'h00, 11'd3);
        push_req(REQ_PUT, CH_RETURN, 11'h000);
        push_req(REQ_PUT, 8'h7E, 11'h000);
        push_req(REQ_PUT, CH_NEWLINE, 11'h000);
        push_req(REQ_NONE, 8'hFF, 11'h7FF);
        push_req(REQ_READ, 8'h00, 11'd1);
        push_req(REQ_READ, 8'h00, 11'(COLS));
        push_req(REQ_CLEAR, 8'hFF, 11'h7FF);
        push_req(REQ_READ, 8'h00, 11'd0);
        push_req(REQ_READ, 8'h00, 11'(CELLS - 1));
        push_req(REQ_PUT, 8'h80, 11'h000);
        push_req(REQ_READ, 8'h00, 11'd0);
        wait_idle();

        apb_write(ATTR_ADDR, 8'h00);
        apb_check_attr();
        // tab that hits the row end, then enough newlines to scroll
        push_req(REQ_CLEAR, 8'h00, 11'h000);
        push_req(REQ_PUT, 8'h61, 11'h000);
        push_req(REQ_PUT, 8'h62, 11'h000);
        for (int i = 0; i < 19; i++)
            push_req(REQ_PUT, CH_TAB, 11'h000);
        push_req(REQ_PUT, 8'h78, 11'h000);
        push_req(REQ_PUT, CH_TAB, 11'h000);
        push_req(REQ_READ, 8'h00, 11'(COLS - 1));
        push_req(REQ_READ, 8'h00, 11'(COLS));
        for (int i = 0; i < ROWS; i++)
            push_req(REQ_PUT, CH_NEWLINE, 11'h000);
        push_req(REQ_READ, 8'h00, 11'd0);
        push_req(REQ_READ, 8'h00, 11'(CELLS - 1));
        add_random(440);
        wait_idle();

        src_idle_pct = 51;
        apb_write(ATTR_ADDR, 8'($urandom));
        apb_check_attr();
        add_random(440);
        wait_idle();

        src_idle_pct = 0;
        snk_stall_pct = 51;
        apb_write(ATTR_ADDR, 8'($urandom));
        apb_check_attr();
        add_random(440);
        wait_idle();

        src_idle_pct = 25;
        snk_stall_pct = 25;
        apb_write(ATTR_ADDR, ATTR_RESET);
        apb_check_attr();
        add_random(440);
        wait_idle();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[text_mode_terminal_writer_unit.f]
+incdir+rtl
rtl/tmtw_pkg.sv
rtl/tmtw_ctrl.sv
rtl/tmtw_dp.sv
rtl/text_mode_terminal_writer_unit.sv
rtl/tmtw_chk.sv
test/text_mode_terminal_writer_unit_tb.sv
